FILE: sv/tptf_pkg.sv
// Shared types and constants for the task phase table scheduler.
// Used by the scheduler top level, the ready queue and the testbench; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package tptf_pkg;

	localparam int TASK_W  = 6;
	localparam int LANE_W  = 8;
	localparam int TAG_W   = 16;
	localparam int CNT_W   = 32;

	typedef enum logic [2:0] {
		REQ_INIT           = 3'd0,
		REQ_BEGIN_SUSPEND  = 3'd1,
		REQ_READY          = 3'd2,
		REQ_COMMIT_SUSPEND = 3'd3,
		REQ_CANCEL_SUSPEND = 3'd4,
		REQ_COMPLETE       = 3'd5,
		REQ_POP_RUN        = 3'd6,
		REQ_QUERY_DONE     = 3'd7
	} req_t;

	typedef enum logic [2:0] {
		PH_NONE       = 3'd0,
		PH_RUNNING    = 3'd1,
		PH_SUSPENDING = 3'd2,
		PH_SUSPENDED  = 3'd3,
		PH_NOTIFIED   = 3'd4,
		PH_READY      = 3'd5,
		PH_DONE       = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ERR  = 2'd1,
		ST_IDLE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_EXEC,
		FSM_HELP
	} fsm_t;

	typedef struct packed {
		logic [2:0]        req_type;
		logic [TASK_W-1:0] task_id;
		logic [LANE_W-1:0] lane_id;
		logic [TAG_W-1:0]  resume_tag;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [TASK_W-1:0] run_task;
		logic [TAG_W-1:0]  run_resume_tag;
		logic              task_done;
		logic              wake_pulse;
		logic              notify_pulse;
		logic [CNT_W-1:0]  migration_total;
		logic [CNT_W-1:0]  resume_total;
	} out_item_t;

	// One task slot as held in the table memory.
	typedef struct packed {
		phase_t            phase;
		logic [TAG_W-1:0]  tag;
		logic [LANE_W-1:0] origin;
	} entry_t;

	typedef struct packed {
		logic              rd;
		logic              push;
		logic              pop;
		logic [TASK_W-1:0] push_data;
	} fifo_ctl_t;

	typedef struct packed {
		logic              empty;
		logic              full;
		logic [TASK_W-1:0] rd_data;
	} fifo_sts_t;

endpackage

`default_nettype wire

FILE: sv/task_phase_table_with_ready_fifo_unit.sv
// Top level of the task scheduler: slot table memory, request sequencer,
// counters and result register. Depends on tptf_pkg, tptf_ram, tptf_fifo.
//
//  channel | valid     | stall     | payload
//  request | req_valid | req_stall | req_data (in_item_t)
//  result  | rsp_valid | rsp_stall | rsp_data (out_item_t)
//
// A request first reads its slot from the table memory, then decides and writes
// back. A pop-and-run request with a non-empty queue takes a further step,
// as the popped task's slot is read only once the queue head is known.
// After reset a clearing pass writes every slot, with no request taken.
// A new request is taken while an earlier result waits; the final step of a request
// waits for the result register to be free.
`timescale 1ns / 1ps
`default_nettype none

module task_phase_table_with_ready_fifo_unit #(
	parameter int QUEUE_DEPTH = 64,
	parameter int TASK_SLOTS  = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output      logic                  req_stall,
	input  wire tptf_pkg::in_item_t    req_data,
	output      logic                  rsp_valid,
	input  wire logic                  rsp_stall,
	output      tptf_pkg::out_item_t   rsp_data
);

	import tptf_pkg::*;

	localparam int SLOT_W = $clog2(TASK_SLOTS);
	localparam int CMP_W = ((SLOT_W > TASK_W) ? SLOT_W : TASK_W) + 1;
	localparam logic [CMP_W-1:0] SLOTS_L = CMP_W'(TASK_SLOTS);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TASK_SLOTS - 1);
	localparam int ENTRY_W = $bits(entry_t);

	fsm_t              state_q, state_d;
	logic [SLOT_W-1:0] clr_idx_q;
	in_item_t          req_q;
	out_item_t         rsp_q, rsp_d;
	logic              rsp_valid_q;
	logic              rsp_load;
	logic [CNT_W-1:0]  mig_q, mig_d;
	logic [CNT_W-1:0]  res_q, res_d;

	logic               tbl_we, tbl_re;
	logic [SLOT_W-1:0]  tbl_waddr, tbl_raddr;
	entry_t             tbl_wdata;
	logic [ENTRY_W-1:0] tbl_rdata;
	entry_t             ent;

	fifo_ctl_t fifo_ctl;
	fifo_sts_t fifo_sts;

	logic    out_free;
	logic    slot_ok;
	logic    pop_ok;
	logic    upd;
	logic    enq;
	req_t    rq;
	entry_t  wr_ent;

	tptf_ram #(
		.DEPTH (TASK_SLOTS),
		.WIDTH (ENTRY_W)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.re    (tbl_re),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	tptf_fifo #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (fifo_ctl),
		.sts    (fifo_sts)
	);

	assign ent      = entry_t'(tbl_rdata);
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign rq       = req_t'(req_q.req_type);
	assign slot_ok  = (CMP_W'(req_q.task_id) < SLOTS_L);
	assign pop_ok   = (CMP_W'(fifo_sts.rd_data) < SLOTS_L) && (ent.phase == PH_READY);

	always_comb begin
		state_d  = state_q;
		tbl_re   = 1'b0;
		tbl_raddr = SLOT_W'(req_data.task_id);
		tbl_we   = 1'b0;
		tbl_waddr = SLOT_W'(req_q.task_id);
		tbl_wdata = '0;
		fifo_ctl = '0;
		fifo_ctl.push_data = req_q.task_id;
		rsp_load = 1'b0;
		mig_d    = mig_q;
		res_d    = res_q;
		upd      = 1'b0;
		enq      = 1'b0;
		wr_ent   = ent;
		rsp_d    = '0;
		rsp_d.status = ST_OK;
		rsp_d.migration_total = mig_q;
		rsp_d.resume_total    = res_q;

		unique case (state_q)
			FSM_CLEAR: begin
				tbl_we    = 1'b1;
				tbl_waddr = clr_idx_q;
				if (clr_idx_q == SLOT_LAST) begin
					state_d = FSM_IDLE;
				end
			end
			FSM_IDLE: begin
				if (req_valid) begin
					tbl_re      = 1'b1;
					fifo_ctl.rd = 1'b1;
					state_d     = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				if (rq != REQ_POP_RUN && !slot_ok) begin
					rsp_d.status = ST_ERR;
				end else begin
					unique case (rq)
						REQ_INIT: begin
							upd = 1'b1;
							wr_ent.phase  = PH_RUNNING;
							wr_ent.tag    = '0;
							wr_ent.origin = req_q.lane_id;
						end
						REQ_BEGIN_SUSPEND: begin
							if (req_q.resume_tag == '0 || ent.phase != PH_RUNNING) begin
								rsp_d.status = ST_ERR;
							end else begin
								upd = 1'b1;
								wr_ent.phase = PH_SUSPENDING;
								wr_ent.tag   = req_q.resume_tag;
							end
						end
						REQ_READY: begin
							priority if (ent.phase == PH_SUSPENDING) begin
								upd = 1'b1;
								wr_ent.phase = PH_NOTIFIED;
							end else if (ent.phase == PH_SUSPENDED) begin
								enq = 1'b1;
							end else begin
								rsp_d.status = ST_ERR;
							end
						end
						REQ_COMMIT_SUSPEND: begin
							priority if (ent.phase == PH_SUSPENDING) begin
								upd = 1'b1;
								wr_ent.phase = PH_SUSPENDED;
							end else if (ent.phase == PH_NOTIFIED) begin
								enq = 1'b1;
							end else begin
								rsp_d.status = ST_ERR;
							end
						end
						REQ_CANCEL_SUSPEND: begin
							if (ent.phase == PH_SUSPENDING) begin
								upd = 1'b1;
								wr_ent.phase = PH_RUNNING;
							end else begin
								rsp_d.status = ST_ERR;
							end
						end
						REQ_COMPLETE: begin
							if (ent.phase == PH_RUNNING) begin
								upd = 1'b1;
								wr_ent.phase = PH_DONE;
								rsp_d.notify_pulse = 1'b1;
							end else begin
								rsp_d.status = ST_ERR;
							end
						end
						REQ_POP_RUN: begin
							if (fifo_sts.empty) begin
								rsp_d.status = ST_IDLE;
							end
						end
						REQ_QUERY_DONE: begin
							rsp_d.task_done = (ent.phase == PH_DONE);
						end
					endcase
				end

				// A task becoming ready goes into the queue unless it is full.
				if (enq) begin
					if (fifo_sts.full) begin
						rsp_d.status = ST_ERR;
					end else begin
						upd = 1'b1;
						wr_ent.phase = PH_READY;
						rsp_d.wake_pulse   = 1'b1;
						rsp_d.notify_pulse = 1'b1;
					end
				end

				if (rq == REQ_POP_RUN && !fifo_sts.empty) begin
					// The queue head is now known: fetch that task's slot.
					tbl_re    = 1'b1;
					tbl_raddr = SLOT_W'(fifo_sts.rd_data);
					state_d   = FSM_HELP;
				end else if (out_free) begin
					rsp_load      = 1'b1;
					tbl_we        = upd;
					tbl_wdata     = wr_ent;
					fifo_ctl.push = enq && upd;
					state_d       = FSM_IDLE;
				end
			end
			FSM_HELP: begin
				tbl_waddr = SLOT_W'(fifo_sts.rd_data);
				if (pop_ok) begin
					wr_ent.phase = PH_RUNNING;
					res_d = (res_q == '1) ? res_q : res_q + CNT_W'(1);
					if (ent.origin != req_q.lane_id) begin
						mig_d = (mig_q == '1) ? mig_q : mig_q + CNT_W'(1);
					end
					rsp_d.run_task       = fifo_sts.rd_data;
					rsp_d.run_resume_tag = ent.tag;
				end else begin
					rsp_d.status = ST_IDLE;
				end
				rsp_d.migration_total = mig_d;
				rsp_d.resume_total    = res_d;
				if (out_free) begin
					rsp_load     = 1'b1;
					tbl_we       = pop_ok;
					tbl_wdata    = wr_ent;
					fifo_ctl.pop = 1'b1;
					state_d      = FSM_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_CLEAR;
			clr_idx_q   <= '0;
			rsp_valid_q <= 1'b0;
			mig_q       <= '0;
			res_q       <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == FSM_CLEAR) begin
				clr_idx_q <= clr_idx_q + SLOT_W'(1);
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
				mig_q       <= mig_d;
				res_q       <= res_d;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FSM_IDLE && req_valid) begin
			req_q <= req_data;
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign req_stall = (state_q != FSM_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	a_accept_leads_exec: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> state_q == FSM_EXEC)
		else $error("accepted item did not move to the execute step");

	a_mig_le_res: assert property (@(posedge clk) disable iff (!arst_n)
		mig_q <= res_q)
		else $error("migration count exceeds resume count");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |-> out_free)
		else $error("result register overwritten while held");

	a_help_pops: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_HELP && out_free |-> fifo_ctl.pop && !fifo_ctl.push)
		else $error("help step finished without popping the queue");

endmodule

`default_nettype wire

FILE: sv/tptf_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data. Stands alone, no package needed.
`timescale 1ns / 1ps
`default_nettype none

module tptf_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds until the next read, so a stalled consumer keeps it.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/tptf_fifo.sv
// Ready queue of task numbers: storage in tptf_ram, head, tail and fill here.
// Depends on tptf_pkg and tptf_ram.
`timescale 1ns / 1ps
`default_nettype none

module tptf_fifo #(
	parameter int QUEUE_DEPTH = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire tptf_pkg::fifo_ctl_t  ctl,
	output      tptf_pkg::fifo_sts_t  sts
);

	import tptf_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);

	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  tail_q;
	logic [FILL_W-1:0] fill_q;
	logic [TASK_W-1:0] rd_data;

	tptf_ram #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH (TASK_W)
	) u_mem (
		.clk   (clk),
		.we    (ctl.push),
		.waddr (tail_q),
		.wdata (ctl.push_data),
		.re    (ctl.rd),
		.raddr (head_q),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else begin
			if (ctl.push) begin
				tail_q <= (tail_q == PTR_LAST) ? '0 : tail_q + PTR_W'(1);
				fill_q <= fill_q + FILL_W'(1);
			end else if (ctl.pop) begin
				head_q <= (head_q == PTR_LAST) ? '0 : head_q + PTR_W'(1);
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

	assign sts.empty   = (fill_q == '0);
	assign sts.full    = (fill_q == FILL_MAX);
	assign sts.rd_data = rd_data;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_MAX)
		else $error("ready queue fill beyond depth");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |-> !sts.full)
		else $error("push into a full ready queue");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> !sts.empty)
		else $error("pop from an empty ready queue");

	a_no_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.push && ctl.pop))
		else $error("push and pop in the same cycle");

endmodule

`default_nettype wire

FILE: verif/tptf_sched_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the task scheduler: its own slot table and ready queue predict
// the result of every accepted request, compared field by field with the block.
// Depends on tptf_pkg only.
module tptf_sched_checker (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	input  wire logic                req_stall,
	input  wire tptf_pkg::in_item_t  req_data,
	input  wire logic                rsp_valid,
	input  wire logic                rsp_stall,
	input  wire tptf_pkg::out_item_t rsp_data,
	output int unsigned              fail_count,
	output int unsigned              due_count
);
	import tptf_pkg::*;

	localparam int SLOTS  = 64;
	localparam int QDEPTH = 64;

	phase_t            slot_phase [SLOTS];
	logic [TAG_W-1:0]  slot_tag [SLOTS];
	logic [LANE_W-1:0] slot_origin [SLOTS];
	logic [TASK_W-1:0] ready_q [QDEPTH];
	logic [TASK_W-1:0] q_head, q_tail;
	logic [6:0]        q_fill;
	logic [CNT_W-1:0]  migrations, resumes;
	out_item_t         due_results [$];
	int unsigned       fails = 0;

	initial begin
		fail_count = 0;
		due_count = 0;
	end

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// Applies one request to the scheduler state and returns the result it causes.
	function automatic out_item_t schedule_step(input in_item_t it);
		out_item_t         r;
		phase_t            ph;
		logic [TASK_W-1:0] t;
		logic [TASK_W-1:0] popped;
		r = '0;
		r.status = ST_OK;
		t = it.task_id;
		ph = slot_phase[t];
		case (req_t'(it.req_type))
			REQ_INIT: begin
				slot_phase[t] = PH_RUNNING;
				slot_tag[t] = '0;
				slot_origin[t] = it.lane_id;
			end
			REQ_BEGIN_SUSPEND: begin
				if (it.resume_tag == '0 || ph != PH_RUNNING) begin
					r.status = ST_ERR;
				end else begin
					slot_tag[t] = it.resume_tag;
					slot_phase[t] = PH_SUSPENDING;
				end
			end
			REQ_READY, REQ_COMMIT_SUSPEND: begin
				if (ph == PH_SUSPENDING) begin
					slot_phase[t] = (it.req_type == REQ_READY) ? PH_NOTIFIED : PH_SUSPENDED;
				end else if ((it.req_type == REQ_READY && ph == PH_SUSPENDED) ||
						(it.req_type == REQ_COMMIT_SUSPEND && ph == PH_NOTIFIED)) begin
					// A full queue refuses the task and leaves its phase alone.
					if (q_fill >= QDEPTH) begin
						r.status = ST_ERR;
					end else begin
						ready_q[q_tail] = t;
						q_tail = q_tail + 1'b1;
						q_fill = q_fill + 1'b1;
						slot_phase[t] = PH_READY;
						r.wake_pulse = 1'b1;
						r.notify_pulse = 1'b1;
					end
				end else begin
					r.status = ST_ERR;
				end
			end
			REQ_CANCEL_SUSPEND: begin
				if (ph == PH_SUSPENDING)
					slot_phase[t] = PH_RUNNING;
				else
					r.status = ST_ERR;
			end
			REQ_COMPLETE: begin
				if (ph == PH_RUNNING) begin
					slot_phase[t] = PH_DONE;
					r.notify_pulse = 1'b1;
				end else begin
					r.status = ST_ERR;
				end
			end
			REQ_POP_RUN: begin
				if (q_fill == 0) begin
					r.status = ST_IDLE;
				end else begin
					popped = ready_q[q_head];
					q_head = q_head + 1'b1;
					q_fill = q_fill - 1'b1;
					// A stale entry is dropped without running anything.
					if (slot_phase[popped] != PH_READY) begin
						r.status = ST_IDLE;
					end else begin
						slot_phase[popped] = PH_RUNNING;
						if (slot_origin[popped] != it.lane_id)
							migrations = sat_inc(migrations);
						resumes = sat_inc(resumes);
						r.run_task = popped;
						r.run_resume_tag = slot_tag[popped];
					end
				end
			end
			default: begin
				r.task_done = (ph == PH_DONE);
			end
		endcase
		r.migration_total = migrations;
		r.resume_total = resumes;
		return r;
	endfunction

	task automatic check_field(input string what, input logic [CNT_W-1:0] want_v,
			input logic [CNT_W-1:0] got_v);
		if (want_v !== got_v) begin
			if (fails < 10)
				$display("mismatch in %s: expected %h, got %h", what, want_v, got_v);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_phase[i] = PH_NONE;
				slot_tag[i] = '0;
				slot_origin[i] = '0;
			end
			q_head = '0;
			q_tail = '0;
			q_fill = '0;
			migrations = '0;
			resumes = '0;
			due_results.delete();
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (due_results.size() == 0) begin
					if (fails < 10)
						$display("result item with nothing expected: %h", rsp_data);
					fails++;
				end else begin
					want = due_results.pop_front();
					check_field("status", want.status, rsp_data.status);
					check_field("run_task", want.run_task, rsp_data.run_task);
					check_field("run_resume_tag", want.run_resume_tag, rsp_data.run_resume_tag);
					check_field("task_done", want.task_done, rsp_data.task_done);
					check_field("wake_pulse", want.wake_pulse, rsp_data.wake_pulse);
					check_field("notify_pulse", want.notify_pulse, rsp_data.notify_pulse);
					check_field("migration_total", want.migration_total,
						rsp_data.migration_total);
					check_field("resume_total", want.resume_total, rsp_data.resume_total);
				end
			end
			if (req_valid && !req_stall)
				due_results.push_back(schedule_step(req_data));
		end
		due_count <= due_results.size();
		fail_count <= fails;
	end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the task scheduler: drives directed and random request
// items with sender gaps and receiver stalls, and gives the verdict.
// Depends on tptf_pkg, the scheduler RTL and tptf_sched_checker.
module tb_top;
	import tptf_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 300000;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned RANDOM_TARGET = 600;
	localparam int unsigned PHASE_LEN     = 150;
	localparam int unsigned FILL_AT       = 200;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	in_item_t    req_data;
	logic        rsp_valid;
	logic        rsp_stall;
	out_item_t   rsp_data;
	int unsigned fail_count;
	int unsigned due_count;
	int unsigned sent = 0;
	int unsigned cycles = 0;
	int          snd_idle_pct = 0;
	int          rcv_stall_pct = 0;
	logic        pressure_go = 1'b0;

	task_phase_table_with_ready_fifo_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	tptf_sched_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_data   (req_data),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp_data   (rsp_data),
		.fail_count (fail_count),
		.due_count  (due_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	// Result side: random stalls, plus one long hold-off that backs the block up.
	initial begin : receiver
		int   hold;
		logic hold_used;
		hold = 0;
		hold_used = 1'b0;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (pressure_go && !hold_used) begin
				hold = HOLD_CYCLES;
				hold_used = 1'b1;
			end
			if (hold > 0) begin
				rsp_stall = 1'b1;
				hold--;
			end else begin
				rsp_stall = ($urandom_range(99) < rcv_stall_pct);
			end
		end
	end

	function automatic logic [LANE_W-1:0] pick_lane();
		return ($urandom_range(3) == 0) ? LANE_W'($urandom_range(255)) :
			LANE_W'($urandom_range(3));
	endfunction

	// Half of the traffic goes to a few slots so that sequences interfere.
	function automatic logic [TASK_W-1:0] pick_slot();
		return ($urandom_range(1) == 0) ? TASK_W'($urandom_range(7)) :
			TASK_W'($urandom_range(63));
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic issue(input req_t kind, input logic [TASK_W-1:0] slot,
			input logic [LANE_W-1:0] lane, input logic [TAG_W-1:0] tag);
		// The idling mix follows the number of items sent so far.
		if (sent < PHASE_LEN) begin
			snd_idle_pct = 0;
			rcv_stall_pct = 0;
		end else if (sent < 2 * PHASE_LEN) begin
			snd_idle_pct = 60;
			rcv_stall_pct = 0;
		end else if (sent < 3 * PHASE_LEN) begin
			snd_idle_pct = 0;
			rcv_stall_pct = 60;
		end else begin
			snd_idle_pct = 32;
			rcv_stall_pct = 32;
		end
		while ($urandom_range(99) < snd_idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_valid = 1'b1;
		req_data = '{kind, slot, lane, tag};
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic run_lifecycle(input logic [TASK_W-1:0] slot);
		int shape;
		shape = $urandom_range(3);
		issue(REQ_INIT, slot, pick_lane(), TAG_W'($urandom_range(65535)));
		issue(REQ_BEGIN_SUSPEND, slot, pick_lane(), TAG_W'(1 + $urandom_range(65534)));
		case (shape)
			0: begin
				issue(REQ_READY, slot, pick_lane(), TAG_W'($urandom_range(65535)));
				issue(REQ_COMMIT_SUSPEND, slot, pick_lane(), TAG_W'($urandom_range(65535)));
			end
			1: begin
				issue(REQ_COMMIT_SUSPEND, slot, pick_lane(), TAG_W'($urandom_range(65535)));
				issue(REQ_READY, slot, pick_lane(), TAG_W'($urandom_range(65535)));
			end
			2: begin
				issue(REQ_CANCEL_SUSPEND, slot, pick_lane(), TAG_W'($urandom_range(65535)));
				issue(REQ_COMPLETE, slot, pick_lane(), TAG_W'($urandom_range(65535)));
				issue(REQ_QUERY_DONE, slot, pick_lane(), TAG_W'($urandom_range(65535)));
			end
			default: begin
				issue(REQ_COMMIT_SUSPEND, slot, pick_lane(), TAG_W'($urandom_range(65535)));
			end
		endcase
		if ($urandom_range(1) == 1)
			issue(REQ_POP_RUN, TASK_W'($urandom_range(63)), pick_lane(),
				TAG_W'($urandom_range(65535)));
	endtask

	initial begin : stimulus
		int   roll;
		logic filled;
		filled = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: untouched slots, empty queue, null tag, both orders
		// into the queue, a stale queue entry, completion and migration.
		issue(REQ_QUERY_DONE, 6'd0, 8'd0, 16'h0000);
		issue(REQ_BEGIN_SUSPEND, 6'd1, 8'd0, 16'h0005);
		issue(REQ_POP_RUN, 6'd0, 8'd0, 16'h0000);
		issue(REQ_INIT, 6'd63, 8'hFF, 16'hFFFF);
		issue(REQ_BEGIN_SUSPEND, 6'd63, 8'hFF, 16'h0000);
		issue(REQ_BEGIN_SUSPEND, 6'd63, 8'hFF, 16'hFFFF);
		issue(REQ_CANCEL_SUSPEND, 6'd63, 8'hFF, 16'h0000);
		issue(REQ_BEGIN_SUSPEND, 6'd63, 8'hFF, 16'h0001);
		issue(REQ_READY, 6'd63, 8'hFF, 16'h0000);
		issue(REQ_READY, 6'd63, 8'hFF, 16'h0000);
		issue(REQ_COMMIT_SUSPEND, 6'd63, 8'hFF, 16'h0000);
		issue(REQ_POP_RUN, 6'd63, 8'h00, 16'h0000);
		issue(REQ_INIT, 6'd0, 8'h00, 16'h0000);
		issue(REQ_BEGIN_SUSPEND, 6'd0, 8'h00, 16'h8000);
		issue(REQ_COMMIT_SUSPEND, 6'd0, 8'h00, 16'h0000);
		issue(REQ_READY, 6'd0, 8'h00, 16'h0000);
		issue(REQ_INIT, 6'd0, 8'h00, 16'h0000);
		issue(REQ_POP_RUN, 6'd0, 8'h00, 16'h0000);
		issue(REQ_COMPLETE, 6'd0, 8'h00, 16'h0000);
		issue(REQ_QUERY_DONE, 6'd0, 8'h00, 16'h0000);
		issue(REQ_COMPLETE, 6'd0, 8'h00, 16'h0000);
		issue(REQ_CANCEL_SUSPEND, 6'd63, 8'h00, 16'h0000);
		issue(REQ_INIT, 6'd5, 8'hAA, 16'h0000);
		issue(REQ_BEGIN_SUSPEND, 6'd5, 8'hAA, 16'h5555);
		issue(REQ_COMMIT_SUSPEND, 6'd5, 8'hAA, 16'h0000);
		issue(REQ_READY, 6'd5, 8'hAA, 16'h0000);
		issue(REQ_POP_RUN, 6'd9, 8'hAA, 16'h0000);

		while (sent < RANDOM_TARGET) begin
			if (sent >= 100)
				pressure_go = 1'b1;
			if (sent >= FILL_AT && !filled) begin
				filled = 1'b1;
				// Make every slot ready so the queue fills, push once more into
				// the full queue, then drain it past empty.
				for (int s = 0; s < 64; s++) begin
					issue(REQ_INIT, TASK_W'(s), pick_lane(), TAG_W'($urandom_range(65535)));
					issue(REQ_BEGIN_SUSPEND, TASK_W'(s), pick_lane(),
						TAG_W'(1 + $urandom_range(65534)));
					issue(REQ_COMMIT_SUSPEND, TASK_W'(s), pick_lane(), '0);
					issue(REQ_READY, TASK_W'(s), pick_lane(), '0);
				end
				issue(REQ_INIT, 6'd0, pick_lane(), '0);
				issue(REQ_BEGIN_SUSPEND, 6'd0, pick_lane(), 16'h1234);
				issue(REQ_READY, 6'd0, pick_lane(), '0);
				issue(REQ_COMMIT_SUSPEND, 6'd0, pick_lane(), '0);
				repeat (70)
					issue(REQ_POP_RUN, TASK_W'($urandom_range(63)), pick_lane(),
						TAG_W'($urandom_range(65535)));
			end
			roll = $urandom_range(99);
			if (roll < 65)
				run_lifecycle(pick_slot());
			else if (roll < 85)
				issue(REQ_POP_RUN, TASK_W'($urandom_range(63)), pick_lane(),
					TAG_W'($urandom_range(65535)));
			else
				issue(req_t'($urandom_range(7)), TASK_W'($urandom_range(63)),
					LANE_W'($urandom_range(255)), TAG_W'($urandom_range(65535)));
		end
		req_valid = 1'b0;

		while (due_count != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: sim.f
sv/tptf_pkg.sv
sv/tptf_ram.sv
sv/tptf_fifo.sv
sv/task_phase_table_with_ready_fifo_unit.sv
verif/tptf_sched_checker.sv
verif/tb_top.sv
